FILE: hw/rtl/ost_pkg.sv
`default_nettype none

package ost_pkg;

    // Number of values the table can hold.
    localparam int SET_CAPACITY = 16;

    // Width of the internal fill count, wide enough to hold the capacity itself.
    localparam int COUNT_W = $clog2(SET_CAPACITY + 1);

    // Field widths fixed by the interface.
    localparam int VALUE_W        = 32;
    localparam int MEMBER_COUNT_W = 5;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // One input item.
    typedef struct packed {
        t_cmd                       cmd;
        logic signed [VALUE_W-1:0]  value;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic                       was_member;
        logic                       changed;
        logic                       full_error;
        logic [MEMBER_COUNT_W-1:0]  member_count;
    } t_out_item;

    // Per-cell control from the table controller.
    typedef struct packed {
        logic used;   // The cell lies below the fill count.
        logic load;   // Store the incoming value in this cell.
        logic shift;  // A remove hit: cells at or above the hit take their neighbor's value.
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: hw/rtl/ordered_set_table.sv
// The result of an accepted item is registered and shows on the output register in the next cycle.
// Throughput: one item per cycle while results are taken; every cell compares at once
// and a remove shifts the row down in that same cycle.
// Reset: synchronous, active low; it empties the table and the output register.
// The stored values themselves are not cleared, since only entries below the count are read.
`default_nettype none

module ordered_set_table
    import ost_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_item,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item
);

    logic [COUNT_W-1:0]        r_count;
    logic [COUNT_W-1:0]        n_count;
    logic                      r_out_valid;
    logic                      n_out_valid;
    t_out_item                 r_out_item;
    t_out_item                 n_out_item;

    logic                      w_accept;
    logic                      w_was;
    logic                      w_full;
    logic                      w_add_ok;
    logic                      w_remove_hit;

    t_cell_ctrl                w_ctrl  [SET_CAPACITY];
    logic signed [VALUE_W-1:0] w_value [SET_CAPACITY];
    logic                      w_seen  [SET_CAPACITY+1];

    // A new item enters when the output register is empty or being emptied.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Decode the command against the present contents.
    assign w_seen[0]    = 1'b0;
    assign w_was        = (i_in_item.cmd != CMD_CLEAR) && w_seen[SET_CAPACITY];
    assign w_full       = r_count >= COUNT_W'(SET_CAPACITY);
    assign w_add_ok     = w_accept && (i_in_item.cmd == CMD_ADD) && !w_was && !w_full;
    assign w_remove_hit = w_accept && (i_in_item.cmd == CMD_REMOVE) && w_was;

    // Row of cells; the top cell has no upper neighbor and keeps its own value.
    for (genvar k = 0; k < SET_CAPACITY; k++) begin : g_cell
        assign w_ctrl[k].used  = COUNT_W'(k) < r_count;
        assign w_ctrl[k].load  = w_add_ok && (r_count == COUNT_W'(k));
        assign w_ctrl[k].shift = w_remove_hit;

        ost_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl[k]),
            .i_query      (i_in_item.value),
            .i_next_value ((k == SET_CAPACITY - 1) ? w_value[k]
                                                   : w_value[(k + 1) % SET_CAPACITY]),
            .i_seen       (w_seen[k]),
            .o_value      (w_value[k]),
            .o_seen       (w_seen[k+1])
        );
    end

    // Next count and the result item.
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        if (w_accept) begin
            case (i_in_item.cmd)
                CMD_CLEAR:  n_count = '0;
                CMD_ADD:    if (w_add_ok) n_count = r_count + COUNT_W'(1);
                CMD_REMOVE: if (w_remove_hit) n_count = r_count - COUNT_W'(1);
                default:    n_count = r_count;
            endcase
            n_out_valid             = 1'b1;
            n_out_item.was_member   = w_was;
            n_out_item.changed      = w_add_ok || w_remove_hit;
            n_out_item.full_error   = (i_in_item.cmd == CMD_ADD) && !w_was && w_full;
            n_out_item.member_count = MEMBER_COUNT_W'(n_count);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

FILE: hw/rtl/ost_cell.sv
`default_nettype none

module ost_cell
    import ost_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire t_cell_ctrl                 i_ctrl,
    input  wire logic signed [VALUE_W-1:0]  i_query,
    input  wire logic signed [VALUE_W-1:0]  i_next_value,
    input  wire logic                       i_seen,
    output logic signed [VALUE_W-1:0]       o_value,
    output logic                            o_seen
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      w_match;

    // A used cell matches when it holds the queried value.
    assign w_match = i_ctrl.used && (r_value == i_query);

    // The hit travels up the row, so every cell at or above it knows.
    assign o_seen  = i_seen || w_match;
    assign o_value = r_value;

    // Load a new value, or move down when a remove hit lies at or below this cell.
    always_comb begin
        n_value = r_value;
        if (i_ctrl.load) begin
            n_value = i_query;
        end else if (i_ctrl.shift && o_seen) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire
